/* hw/rtl/cqs_pkg.sv */
// shared types, codes and constants of the stop-and-wait command sender
package cqs_pkg;

  // default queue depth
  localparam int unsigned QueueDepthDef = 16;

  // payload widths
  localparam int unsigned ModeW    = 3;
  localparam int unsigned TypeW    = 8;
  localparam int unsigned HandleW  = 16;
  localparam int unsigned SeqW     = 4;
  localparam int unsigned AttemptW = 4;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned RetryW   = 4;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // reset values of the registers
  localparam logic [TimeoutW-1:0] TimeoutRst = 16'd100;
  localparam logic [RetryW-1:0]   RetryRst   = 4'd3;

  // sequence numbers cycle through this range
  localparam logic [SeqW-1:0] SeqFirst = 4'd1;
  localparam logic [SeqW-1:0] SeqMax   = 4'd9;

  typedef enum logic [ModeW-1:0] {
    MODE_ENQUEUE   = 3'd0,
    MODE_REPLY     = 3'd1,
    MODE_TICK      = 3'd2,
    MODE_LINK_UP   = 3'd3,
    MODE_LINK_DOWN = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 3'd0,
    ST_LINK_REJECT = 3'd1,
    ST_QUEUE_FULL  = 3'd2,
    ST_REPLY_MATCH = 3'd3,
    ST_UNSOLICITED = 3'd4,
    ST_MISMATCH    = 3'd5,
    ST_ABANDONED   = 3'd6
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT = 1'd0,
    CFG_RETRIES = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_SEND,
    S_EMIT
  } state_e;

  // one queued command
  typedef struct packed {
    logic [TypeW-1:0]   cmd_type;
    logic [HandleW-1:0] handle;
  } entry_t;

  // one result beat, without the queue count
  typedef struct packed {
    logic                transmit;
    logic [TypeW-1:0]    tx_cmd_type;
    logic [HandleW-1:0]  tx_handle;
    logic [SeqW-1:0]     tx_seq;
    logic [AttemptW-1:0] tx_attempt;
    status_e             status;
    logic [HandleW-1:0]  done_handle;
  } res_t;

endpackage

/* hw/rtl/cqs_channels.sv */
// valid/ready channels for events in and results out
interface cqs_evt_if
  import cqs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ModeW-1:0]   mode;
  logic [TypeW-1:0]   cmd_type;
  logic [HandleW-1:0] cmd_handle;
  logic [SeqW-1:0]    reply_seq;

  modport source (output valid, mode, cmd_type, cmd_handle, reply_seq, input ready);
  modport sink   (input valid, mode, cmd_type, cmd_handle, reply_seq, output ready);
endinterface

interface cqs_res_if
  import cqs_pkg::*;
#(
  parameter int unsigned CountW = 5
) ();
  logic                valid;
  logic                ready;
  logic                transmit;
  logic [TypeW-1:0]    tx_cmd_type;
  logic [HandleW-1:0]  tx_handle;
  logic [SeqW-1:0]     tx_seq;
  logic [AttemptW-1:0] tx_attempt;
  logic [StatusW-1:0]  status;
  logic [HandleW-1:0]  done_handle;
  logic [CountW-1:0]   queue_count;

  modport source (output valid, transmit, tx_cmd_type, tx_handle, tx_seq, tx_attempt,
                  status, done_handle, queue_count, input ready);
  modport sink   (input valid, transmit, tx_cmd_type, tx_handle, tx_seq, tx_attempt,
                  status, done_handle, queue_count, output ready);
endinterface

/* hw/rtl/command_queue_stop_and_wait_sender.sv */
// Stop-and-wait command sender: command queue in a synchronous RAM plus send/retry control.
// Each event beat is accepted in S_IDLE, executed in S_EXEC and its result registered in
// S_EMIT; when a reply or an abandon frees the head and the next command is sent, S_FETCH
// and S_SEND come between (the new head is read from the RAM). Events are taken one at a
// time, the next only after the last result has left S_EMIT, which waits on a stalled result.
// Reset: queue empty, link down, nothing pending, next sequence 1, timeout 100, retries 3.
module command_queue_stop_and_wait_sender
  import cqs_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef,
  parameter int unsigned CountW     = $clog2(QueueDepth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  cqs_evt_if.sink             evt_i,
  cqs_res_if.source           res_o
);

  localparam int unsigned AddrW = $clog2(QueueDepth);

  // control and queue state
  state_e              state_q, state_d;
  logic [AddrW-1:0]    head_q, head_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                link_q, link_d;
  logic                await_q, await_d;
  logic [SeqW-1:0]     nseq_q, nseq_d;
  logic [SeqW-1:0]     hseq_q, hseq_d;
  logic [RetryW-1:0]   retry_q, retry_d;
  logic [TimeoutW-1:0] tmo_cnt_q, tmo_cnt_d;
  logic [TimeoutW-1:0] tmo_cfg_q;
  logic [RetryW-1:0]   max_retry_q;

  // latched event
  logic [ModeW-1:0]    mode_q;
  logic [TypeW-1:0]    typ_q;
  logic [HandleW-1:0]  hdl_q;
  logic [SeqW-1:0]     rseq_q;

  // result staging and output register
  res_t                res_q, res_d;
  res_t                out_q;
  logic [CountW-1:0]   out_cnt_q;
  logic                out_valid_q;

  // command RAM
  entry_t              mem [QueueDepth];
  entry_t              rd_data_q;
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;

  // datapath helpers
  entry_t              head_ent;
  entry_t              send_ent;
  entry_t              new_ent;
  logic                do_send;
  logic                need_fetch;
  logic                slot_free;
  logic [SeqW-1:0]     send_seq;
  logic [AddrW:0]      tail_sum;
  logic [AddrW-1:0]    tail_addr;
  logic [AddrW-1:0]    head_inc;
  logic [TimeoutW-1:0] tmo_inc;
  logic                accept;

  assign accept    = evt_i.valid && evt_i.ready;
  assign slot_free = !out_valid_q || res_o.ready;
  assign evt_i.ready = (state_q == S_IDLE);

  // queue address arithmetic, wraps at any depth
  assign tail_sum  = {1'b0, head_q} + (AddrW + 1)'(count_q);
  assign tail_addr = (tail_sum >= (AddrW + 1)'(QueueDepth)) ?
                     AddrW'(tail_sum - (AddrW + 1)'(QueueDepth)) : AddrW'(tail_sum);
  assign head_inc  = (head_q == AddrW'(QueueDepth - 1)) ? '0 : head_q + AddrW'(1);

  // saturating tick count
  assign tmo_inc = (tmo_cnt_q != '1) ? tmo_cnt_q + TimeoutW'(1) : tmo_cnt_q;

  // head of queue, forwarded from the event when the queue is empty
  assign new_ent  = '{cmd_type: typ_q, handle: hdl_q};
  assign head_ent = (count_q == '0) ? new_ent : rd_data_q;

  // fresh sequence number for a first send
  assign send_seq = (nseq_q < SeqFirst || nseq_q > SeqMax) ? SeqFirst : nseq_q;

  // command RAM, one write and one registered read of the head per cycle
  // not cleared at reset, only occupied entries are ever used
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= new_ent;
    end
    rd_data_q <= mem[head_q];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (evt_i.valid) state_d = S_EXEC;
      S_EXEC:  state_d = need_fetch ? S_FETCH : S_EMIT;
      S_FETCH: state_d = S_SEND;
      S_SEND:  state_d = S_EMIT;
      S_EMIT:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // event execution and send decision
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    link_d     = link_q;
    await_d    = await_q;
    nseq_d     = nseq_q;
    hseq_d     = hseq_q;
    retry_d    = retry_q;
    tmo_cnt_d  = tmo_cnt_q;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = tail_addr;
    need_fetch = 1'b0;
    do_send    = 1'b0;
    send_ent   = head_ent;

    case (state_q)
      S_EXEC: begin
        res_d        = '0;
        res_d.status = ST_OK;
        case (mode_q)
          MODE_ENQUEUE: begin
            if (!link_q) begin
              res_d.status = ST_LINK_REJECT;
            end else if (count_q == CountW'(QueueDepth)) begin
              res_d.status = ST_QUEUE_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CountW'(1);
              do_send = !await_q;
            end
          end
          MODE_REPLY: begin
            if (!await_q || count_q == '0) begin
              res_d.status = ST_UNSOLICITED;
            end else if (head_ent.cmd_type != typ_q || hseq_q != rseq_q) begin
              res_d.status = ST_MISMATCH;
            end else begin
              res_d.status      = ST_REPLY_MATCH;
              res_d.done_handle = head_ent.handle;
              head_d     = head_inc;
              count_d    = count_q - CountW'(1);
              await_d    = 1'b0;
              retry_d    = '0;
              tmo_cnt_d  = '0;
              hseq_d     = '0;
              need_fetch = link_q && (count_q != CountW'(1));
            end
          end
          MODE_TICK: begin
            if (await_q && count_q != '0) begin
              tmo_cnt_d = tmo_inc;
              if (tmo_inc >= tmo_cfg_q) begin
                tmo_cnt_d = '0;
                if (retry_q >= max_retry_q) begin
                  res_d.status      = ST_ABANDONED;
                  res_d.done_handle = head_ent.handle;
                  head_d     = head_inc;
                  count_d    = count_q - CountW'(1);
                  await_d    = 1'b0;
                  retry_d    = '0;
                  hseq_d     = '0;
                  need_fetch = link_q && (count_q != CountW'(1));
                end else begin
                  // resend the head with the same sequence number
                  retry_d           = retry_q + RetryW'(1);
                  res_d.transmit    = 1'b1;
                  res_d.tx_cmd_type = head_ent.cmd_type;
                  res_d.tx_handle   = head_ent.handle;
                  res_d.tx_seq      = hseq_q;
                  res_d.tx_attempt  = retry_q + RetryW'(1);
                end
              end
            end
          end
          MODE_LINK_UP: begin
            link_d  = 1'b1;
            do_send = !await_q && (count_q != '0);
          end
          MODE_LINK_DOWN: begin
            link_d    = 1'b0;
            await_d   = 1'b0;
            count_d   = '0;
            head_d    = '0;
            hseq_d    = '0;
            retry_d   = '0;
            tmo_cnt_d = '0;
          end
          default: ;
        endcase
      end
      S_SEND: begin
        send_ent = rd_data_q;
        do_send  = link_q && !await_q && (count_q != '0);
      end
      default: ;
    endcase

    // first send of the head command
    if (do_send) begin
      hseq_d            = send_seq;
      nseq_d            = (send_seq >= SeqMax) ? SeqFirst : send_seq + SeqW'(1);
      retry_d           = '0;
      tmo_cnt_d         = '0;
      await_d           = 1'b1;
      res_d.transmit    = 1'b1;
      res_d.tx_cmd_type = send_ent.cmd_type;
      res_d.tx_handle   = send_ent.handle;
      res_d.tx_seq      = send_seq;
      res_d.tx_attempt  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      link_q      <= 1'b0;
      await_q     <= 1'b0;
      nseq_q      <= SeqFirst;
      hseq_q      <= '0;
      retry_q     <= '0;
      tmo_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      link_q    <= link_d;
      await_q   <= await_d;
      nseq_q    <= nseq_d;
      hseq_q    <= hseq_d;
      retry_q   <= retry_d;
      tmo_cnt_q <= tmo_cnt_d;
      if (state_q == S_EMIT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_cfg_q   <= TimeoutRst;
      max_retry_q <= RetryRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT: tmo_cfg_q   <= cfg_data_i[TimeoutW-1:0];
        CFG_RETRIES: max_retry_q <= cfg_data_i[RetryW-1:0];
        default: ;
      endcase
    end
  end

  // event capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= evt_i.mode;
      typ_q  <= evt_i.cmd_type;
      hdl_q  <= evt_i.cmd_handle;
      rseq_q <= evt_i.reply_seq;
    end
    res_q <= res_d;
    if (state_q == S_EMIT && slot_free) begin
      out_q     <= res_q;
      out_cnt_q <= count_q;
    end
  end

  // result beat
  assign res_o.valid       = out_valid_q;
  assign res_o.transmit    = out_q.transmit;
  assign res_o.tx_cmd_type = out_q.tx_cmd_type;
  assign res_o.tx_handle   = out_q.tx_handle;
  assign res_o.tx_seq      = out_q.tx_seq;
  assign res_o.tx_attempt  = out_q.tx_attempt;
  assign res_o.status      = out_q.status;
  assign res_o.done_handle = out_q.done_handle;
  assign res_o.queue_count = out_cnt_q;

endmodule

/* hw/rtl/cqs_checker.sv */
// port-level assertions of the stop-and-wait command sender, bound to the top level
module cqs_checker
  import cqs_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef,
  parameter int unsigned CountW     = $clog2(QueueDepth + 1)
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic                transmit_i,
  input logic [TypeW-1:0]    tx_cmd_type_i,
  input logic [HandleW-1:0]  tx_handle_i,
  input logic [SeqW-1:0]     tx_seq_i,
  input logic [AttemptW-1:0] tx_attempt_i,
  input logic [StatusW-1:0]  status_i,
  input logic [HandleW-1:0]  done_handle_i,
  input logic [CountW-1:0]   queue_count_i
);

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({transmit_i, tx_cmd_type_i, tx_handle_i, tx_seq_i, tx_attempt_i,
               status_i, done_handle_i, queue_count_i}))
    else $error("result beat changed while stalled");

  // a send always carries a sequence number in range
  a_seq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && transmit_i |-> tx_seq_i >= SeqFirst && tx_seq_i <= SeqMax)
    else $error("send with sequence number out of range");

  // no send means empty send fields
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !transmit_i |->
      tx_seq_i == '0 && tx_attempt_i == '0 && tx_cmd_type_i == '0 && tx_handle_i == '0)
    else $error("send fields set without a send");

  // done handle only for completion or abandon
  a_done_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_REPLY_MATCH && status_i != ST_ABANDONED |->
      done_handle_i == '0)
    else $error("done handle set for a status without a finished command");

  // queue never reports more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> queue_count_i <= CountW'(QueueDepth))
    else $error("queue count above depth");

endmodule

bind command_queue_stop_and_wait_sender cqs_checker #(
  .QueueDepth (QueueDepth),
  .CountW     (CountW)
) u_cqs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .transmit_i    (res_o.transmit),
  .tx_cmd_type_i (res_o.tx_cmd_type),
  .tx_handle_i   (res_o.tx_handle),
  .tx_seq_i      (res_o.tx_seq),
  .tx_attempt_i  (res_o.tx_attempt),
  .status_i      (res_o.status),
  .done_handle_i (res_o.done_handle),
  .queue_count_i (res_o.queue_count)
);

/* verif/command_queue_stop_and_wait_sender_test.sv */
// testbench of the stop-and-wait command sender: directed and random events against a predictor
module command_queue_stop_and_wait_sender_test;
  import cqs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned CountW     = $clog2(QueueDepthDef + 1);
  localparam int unsigned IdxW       = $clog2(QueueDepthDef);
  localparam int unsigned StallLimit = 500;
  localparam int unsigned ModeTop    = (1 << ModeW) - 1;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned PhaseItems = 135;

  // one expected result beat with the queue count
  typedef struct packed {
    res_t              beat;
    logic [CountW-1:0] count;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cqs_evt_if evt_bus ();
  cqs_res_if #(.CountW(CountW)) res_bus ();

  command_queue_stop_and_wait_sender dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_i      (evt_bus),
    .res_o      (res_bus)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // sender model state
  entry_t              cmd_mem [QueueDepthDef];
  logic [IdxW-1:0]     head_idx    = '0;
  int unsigned         n_queued    = 0;
  bit                  link_is_up  = 1'b0;
  bit                  awaiting    = 1'b0;
  logic [SeqW-1:0]     next_seq    = SeqFirst;
  logic [SeqW-1:0]     head_seq    = '0;
  logic [RetryW-1:0]   resends     = '0;
  logic [TimeoutW-1:0] wait_ticks  = '0;
  logic [TimeoutW-1:0] cfg_timeout = TimeoutRst;
  logic [RetryW-1:0]   cfg_retries = RetryRst;

  outcome_t    pending [$];
  bit          failed       = 1'b0;
  bit          idle_en      = 1'b1;
  int unsigned items_sent   = 0;
  int unsigned stall_cycles = 0;

  // send fields for the current head
  function automatic res_t send_beat();
    res_t r;
    r             = '0;
    r.transmit    = 1'b1;
    r.tx_cmd_type = cmd_mem[head_idx].cmd_type;
    r.tx_handle   = cmd_mem[head_idx].handle;
    r.tx_seq      = head_seq;
    r.tx_attempt  = resends;
    return r;
  endfunction

  // first send of the head with a fresh sequence number, if allowed
  function automatic bit start_head();
    if (!link_is_up || awaiting || n_queued == 0) return 1'b0;
    head_seq   = (next_seq < SeqFirst || next_seq > SeqMax) ? SeqFirst : next_seq;
    next_seq   = (head_seq >= SeqMax) ? SeqFirst : head_seq + 1'b1;
    resends    = '0;
    wait_ticks = '0;
    awaiting   = 1'b1;
    return 1'b1;
  endfunction

  // head is done or abandoned
  function automatic void retire_head();
    if (n_queued > 0) begin
      head_idx = head_idx + 1'b1;
      n_queued--;
    end
    awaiting   = 1'b0;
    resends    = '0;
    wait_ticks = '0;
    head_seq   = '0;
  endfunction

  // expected result of one event, updates the model state
  function automatic outcome_t predict_event(logic [ModeW-1:0] mode, logic [TypeW-1:0] ctype,
                                             logic [HandleW-1:0] handle, logic [SeqW-1:0] rseq);
    outcome_t           o;
    logic [IdxW-1:0]    tail;
    logic [HandleW-1:0] done;
    o    = '0;
    done = '0;
    case (mode)
      MODE_ENQUEUE: begin
        if (!link_is_up) begin
          o.beat.status = ST_LINK_REJECT;
        end else if (n_queued >= QueueDepthDef) begin
          o.beat.status = ST_QUEUE_FULL;
        end else begin
          tail = head_idx + n_queued[IdxW-1:0];
          cmd_mem[tail].cmd_type = ctype;
          cmd_mem[tail].handle   = handle;
          n_queued++;
          if (start_head()) o.beat = send_beat();
        end
      end
      MODE_REPLY: begin
        if (!awaiting || n_queued == 0) begin
          o.beat.status = ST_UNSOLICITED;
        end else if (cmd_mem[head_idx].cmd_type != ctype || head_seq != rseq) begin
          o.beat.status = ST_MISMATCH;
        end else begin
          done = cmd_mem[head_idx].handle;
          retire_head();
          if (start_head()) o.beat = send_beat();
          o.beat.status      = ST_REPLY_MATCH;
          o.beat.done_handle = done;
        end
      end
      MODE_TICK: begin
        if (awaiting && n_queued > 0) begin
          if (wait_ticks != '1) wait_ticks++;
          if (wait_ticks >= cfg_timeout) begin
            wait_ticks = '0;
            if (resends >= cfg_retries) begin
              done = cmd_mem[head_idx].handle;
              retire_head();
              if (start_head()) o.beat = send_beat();
              o.beat.status      = ST_ABANDONED;
              o.beat.done_handle = done;
            end else begin
              resends++;
              o.beat = send_beat();
            end
          end
        end
      end
      MODE_LINK_UP: begin
        link_is_up = 1'b1;
        if (start_head()) o.beat = send_beat();
      end
      MODE_LINK_DOWN: begin
        link_is_up = 1'b0;
        awaiting   = 1'b0;
        n_queued   = 0;
        head_idx   = '0;
        head_seq   = '0;
        resends    = '0;
        wait_ticks = '0;
      end
      default: ;
    endcase
    o.count = n_queued[CountW-1:0];
    return o;
  endfunction

  // drive one event beat and record its expected result once accepted
  task automatic send_event(logic [ModeW-1:0] mode, logic [TypeW-1:0] ctype,
                            logic [HandleW-1:0] handle, logic [SeqW-1:0] rseq);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      evt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_bus.valid      <= 1'b1;
    evt_bus.mode       <= mode;
    evt_bus.cmd_type   <= ctype;
    evt_bus.cmd_handle <= handle;
    evt_bus.reply_seq  <= rseq;
    @(posedge clk_i);
    while (!evt_bus.ready) @(posedge clk_i);
    pending.push_back(predict_event(mode, ctype, handle, rseq));
    items_sent++;
  endtask

  // reply that matches the pending head
  task automatic answer_head();
    send_event(MODE_REPLY, cmd_mem[head_idx].cmd_type, HandleW'($urandom), head_seq);
  endtask

  task automatic enqueue_random();
    send_event(MODE_ENQUEUE, TypeW'($urandom), HandleW'($urandom), SeqW'($urandom));
  endtask

  // stop sending and wait until every expected result is in
  task automatic wait_drained();
    evt_bus.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // write both registers while the block is idle
  task automatic set_config(logic [TimeoutW-1:0] timeout, logic [RetryW-1:0] retries);
    logic [CfgDataW-1:0] word;
    wait_drained();
    word              = CfgDataW'($urandom);
    word[RetryW-1:0]  = retries;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TIMEOUT;
    cfg_data_i <= timeout;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RETRIES;
    cfg_data_i <= word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_timeout = timeout;
    cfg_retries = retries;
  endtask

  // events while the link is down, unused modes
  task automatic test_link_down_events();
    send_event(MODE_ENQUEUE, '1, '1, '1);
    send_event(MODE_REPLY, '0, '0, '0);
    send_event(MODE_TICK, '1, '1, '1);
    for (int unsigned m = int'(MODE_LINK_DOWN) + 1; m <= ModeTop; m++) begin
      send_event(ModeW'(m), TypeW'($urandom), HandleW'($urandom), SeqW'($urandom));
    end
    send_event(MODE_LINK_DOWN, '0, '0, '0);
  endtask

  // link up, matching and mismatched replies
  task automatic test_reply_matching();
    send_event(MODE_LINK_UP, '0, '0, '0);
    send_event(MODE_LINK_UP, '0, '0, '0);
    send_event(MODE_ENQUEUE, '1, '1, '0);
    send_event(MODE_REPLY, '0, '0, head_seq);
    send_event(MODE_REPLY, cmd_mem[head_idx].cmd_type, '0, '1);
    send_event(MODE_LINK_UP, '0, '0, '0);
    answer_head();
    send_event(MODE_ENQUEUE, '0, '0, '1);
    answer_head();
  endtask

  // resend and abandon, zero timeout
  task automatic test_timeouts();
    set_config(16'd1, '0);
    enqueue_random();
    send_event(MODE_TICK, '0, '0, '0);
    set_config(16'd1, 4'd1);
    enqueue_random();
    enqueue_random();
    send_event(MODE_TICK, '0, '0, '0);
    send_event(MODE_TICK, '0, '0, '0);
    answer_head();
    set_config('0, 4'd2);
    enqueue_random();
    repeat (3) send_event(MODE_TICK, '0, '0, '0);
  endtask

  // timeout lowered while a reply is pending, then link down with a pending reply
  task automatic test_lowered_timeout();
    set_config('1, '1);
    enqueue_random();
    repeat (4) send_event(MODE_TICK, '0, '0, '0);
    set_config(16'd3, '1);
    send_event(MODE_TICK, '0, '0, '0);
    send_event(MODE_LINK_DOWN, '0, '0, '0);
  endtask

  // fill the queue past its depth
  task automatic test_queue_full();
    send_event(MODE_LINK_UP, '0, '0, '0);
    repeat (QueueDepthDef + 1) enqueue_random();
    repeat (3) answer_head();
    send_event(MODE_LINK_DOWN, '0, '0, '0);
  endtask

  // one random event, mostly well-formed traffic
  task automatic send_random_event();
    int unsigned pick;
    int unsigned burst;
    pick = $urandom_range(0, 99);
    if (!link_is_up && pick < 60) begin
      send_event(MODE_LINK_UP, TypeW'($urandom), HandleW'($urandom), SeqW'($urandom));
    end else if (pick < 30) begin
      enqueue_random();
    end else if (pick < 50 && awaiting) begin
      answer_head();
    end else if (pick < 58) begin
      send_event(MODE_REPLY, TypeW'($urandom), HandleW'($urandom), SeqW'($urandom));
    end else if (pick < 88) begin
      send_event(MODE_TICK, TypeW'($urandom), HandleW'($urandom), SeqW'($urandom));
    end else if (pick < 91) begin
      send_event(MODE_LINK_UP, TypeW'($urandom), HandleW'($urandom), SeqW'($urandom));
    end else if (pick < 94) begin
      send_event(MODE_LINK_DOWN, TypeW'($urandom), HandleW'($urandom), SeqW'($urandom));
    end else if (pick < 97) begin
      send_event(ModeW'($urandom_range(int'(MODE_LINK_DOWN) + 1, ModeTop)),
                 TypeW'($urandom), HandleW'($urandom), SeqW'($urandom));
    end else begin
      burst = $urandom_range(4, QueueDepthDef + 2);
      repeat (burst) enqueue_random();
    end
  endtask

  // phases of random traffic, each with its own register setting
  task automatic test_random_traffic();
    logic [TimeoutW-1:0] timeout;
    logic [RetryW-1:0]   retries;
    int unsigned         phase_end;
    for (int unsigned phase = 0; phase < RandPhases; phase++) begin
      timeout = TimeoutW'($urandom_range(1, 6));
      retries = RetryW'($urandom_range(0, 15));
      case (phase)
        0: begin
          timeout = 16'd1;
          retries = '0;
        end
        1: retries = '1;
        5: timeout = TimeoutW'($urandom_range(7, 65535));
        default: ;
      endcase
      set_config(timeout, retries);
      // no idling in the last phase
      if (phase == RandPhases - 1) idle_en = 1'b0;
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) send_random_event();
    end
  endtask

  // result ready with random stall bursts
  initial begin
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (idle_en && $urandom_range(0, 5) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_beat
    outcome_t want;
    if (rst_ni === 1'b1 && res_bus.valid && res_bus.ready) begin
      if (pending.size() == 0) begin
        $error("result beat with no expectation waiting");
        failed = 1'b1;
      end else begin
        want = pending.pop_front();
        check_field("transmit", want.beat.transmit, res_bus.transmit);
        check_field("tx_cmd_type", want.beat.tx_cmd_type, res_bus.tx_cmd_type);
        check_field("tx_handle", want.beat.tx_handle, res_bus.tx_handle);
        check_field("tx_seq", want.beat.tx_seq, res_bus.tx_seq);
        check_field("tx_attempt", want.beat.tx_attempt, res_bus.tx_attempt);
        check_field("status", int'(want.beat.status), res_bus.status);
        check_field("done_handle", want.beat.done_handle, res_bus.done_handle);
        check_field("queue_count", want.count, res_bus.queue_count);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (evt_bus.valid && evt_bus.ready) ||
        (res_bus.valid && res_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_TIMEOUT;
    cfg_data_i         <= '0;
    evt_bus.valid      <= 1'b0;
    evt_bus.mode       <= MODE_ENQUEUE;
    evt_bus.cmd_type   <= '0;
    evt_bus.cmd_handle <= '0;
    evt_bus.reply_seq  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_link_down_events();
    test_reply_matching();
    test_timeouts();
    test_lowered_timeout();
    test_queue_full();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cqs_pkg.sv
hw/rtl/cqs_channels.sv
hw/rtl/command_queue_stop_and_wait_sender.sv
hw/rtl/cqs_checker.sv
verif/command_queue_stop_and_wait_sender_test.sv
